@@ design/breakpoint_match_unit_assert.svh @@
// Assertion macros for the breakpoint match unit.
`ifndef BREAKPOINT_MATCH_UNIT_ASSERT_SVH
`define BREAKPOINT_MATCH_UNIT_ASSERT_SVH

`ifndef SYNTH
`define BMU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("breakpoint_match_unit: invariant violated");
`define BMU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("breakpoint_match_unit: sequence violated");
`else
`define BMU_ASSERT(lbl, prop)
`define BMU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/bpm_pkg.sv @@
// Shared types and constants for the breakpoint match unit.
package bpm_pkg;

  typedef enum logic [2:0] {
    OP_CHECK_PC       = 3'd0,
    OP_RETIRE         = 3'd1,
    OP_ADD            = 3'd2,
    OP_REMOVE         = 3'd3,
    OP_TOGGLE         = 3'd4,
    OP_QUERY          = 3'd5,
    OP_SET_MODE       = 3'd6,
    OP_CLEAR_COUNTERS = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_RUNNING  = 2'd0,
    MODE_PAUSED   = 2'd1,
    MODE_STEPPING = 2'd2
  } mode_t;

  localparam logic [31:0] ADDR_ALIGN_MASK = ~32'd1;

  typedef struct packed {
    logic remove;
    logic append;
    logic reenable;
  } bpm_ctrl_t;

  typedef struct packed {
    logic found_any;
    logic found_en;
  } bpm_status_t;

endpackage

@@ design/bpm_cell.sv @@
// One breakpoint table cell: address, enable bit, compare and shift from neighbour.
module bpm_cell import bpm_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  bpm_ctrl_t       ctrl,
  input  logic [CW-1:0]   pos,
  input  logic [CW-1:0]   count,
  input  logic [31:0]     key,
  input  logic [31:0]     nb_addr,
  input  logic            nb_valid,
  output logic [31:0]     cell_addr,
  output logic            cell_valid,
  output logic            match_any,
  output logic            match_en
);

  logic [31:0] addr;
  logic        valid;
  logic        in_use;
  logic        do_shift;
  logic        do_load;

  assign in_use    = CW'(IDX) < count;
  assign match_any = in_use && (addr == key);
  assign match_en  = match_any && valid;
  assign do_shift  = ctrl.remove && (CW'(IDX) >= pos);
  assign do_load   = ctrl.append && (CW'(IDX) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (do_shift) begin
      valid <= nb_valid;
    end else if (do_load) begin
      valid <= 1'b1;
    end else if (ctrl.reenable && match_any) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_shift) begin
      addr <= nb_addr;
    end else if (do_load) begin
      addr <= key;
    end
  end

  assign cell_addr  = addr;
  assign cell_valid = valid;

endmodule

@@ design/bpm_chain.sv @@
// Row of breakpoint cells with match reduction and slot encoder.
module bpm_chain import bpm_pkg::*; #(
  parameter int MAX = 16,
  parameter int CW  = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  bpm_ctrl_t     ctrl,
  input  logic [CW-1:0] pos,
  input  logic [CW-1:0] count,
  input  logic [31:0]   key,
  output bpm_status_t   status,
  output logic [CW-1:0] found_idx
);

  logic [31:0]    addr_q  [MAX];
  logic           valid_q [MAX];
  logic [MAX-1:0] m_any;
  logic [MAX-1:0] m_en;

  for (genvar i = 0; i < MAX; i++) begin : g_cell
    logic [31:0] nb_addr;
    logic        nb_valid;
    if (i == MAX - 1) begin : g_end
      assign nb_addr  = '0;
      assign nb_valid = 1'b0;
    end else begin : g_mid
      assign nb_addr  = addr_q[i+1];
      assign nb_valid = valid_q[i+1];
    end
    bpm_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .pos        (pos),
      .count      (count),
      .key        (key),
      .nb_addr    (nb_addr),
      .nb_valid   (nb_valid),
      .cell_addr  (addr_q[i]),
      .cell_valid (valid_q[i]),
      .match_any  (m_any[i]),
      .match_en   (m_en[i])
    );
  end

  // entries are unique, so at most one slot matches
  always_comb begin
    found_idx = '0;
    for (int i = 0; i < MAX; i++) begin
      if (m_any[i]) begin
        found_idx = found_idx | CW'(i);
      end
    end
  end

  assign status.found_any = |m_any;
  assign status.found_en  = |m_en;

endmodule

@@ design/breakpoint_match_unit.sv @@
// Top level of the breakpoint match unit: command decode, mode, counters, result.
//
//  channel   signals                                          handshake
//  command   opcode address bp_index cycles_taken new_mode    start && !busy
//  result    proceed hit run_mode bp_count instr_total        done, one cycle
//            cycles_total
//  config    cfg_wdata (debug_enable)                         cfg_we
//
// One command per cycle; busy stays low. The result is strobed on done in the
// cycle after acceptance. Compare, slot encode and table update complete in the
// accept cycle across the cell row. Reset is synchronous and clears the enable
// bits, count, mode, counters and debug_enable. The receiver cannot stall.
module breakpoint_match_unit import bpm_pkg::*; #(
  parameter int MAX_BREAKPOINTS = 16,
  parameter int CW = $clog2(MAX_BREAKPOINTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    opcode,
  input  logic [31:0]   address,
  input  logic [3:0]    bp_index,
  input  logic [11:0]   cycles_taken,
  input  logic [1:0]    new_mode,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  output logic          done,
  output logic          proceed,
  output logic          hit,
  output logic [1:0]    run_mode,
  output logic [CW-1:0] bp_count,
  output logic [63:0]   instr_total,
  output logic [63:0]   cycles_total
);

`include "breakpoint_match_unit_assert.svh"

  logic          debug_enable;
  mode_t         mode;
  mode_t         mode_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [63:0]   retired_count;
  logic [63:0]   retired_count_next;
  logic [63:0]   cycle_sum;
  logic [63:0]   cycle_sum_next;
  logic          proceed_next;
  logic          hit_next;

  op_t           op;
  logic [31:0]   key;
  bpm_ctrl_t     ctrl;
  logic [CW-1:0] pos;
  bpm_status_t   status;
  logic [CW-1:0] found_idx;
  logic          not_full;

  assign busy     = 1'b0;
  assign op       = op_t'(opcode);
  assign key      = (op == OP_CHECK_PC) ? address : (address & ADDR_ALIGN_MASK);
  assign not_full = count < CW'(MAX_BREAKPOINTS);

  bpm_chain #(.MAX(MAX_BREAKPOINTS), .CW(CW)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .pos       (pos),
    .count     (count),
    .key       (key),
    .status    (status),
    .found_idx (found_idx)
  );

  always_comb begin
    ctrl               = '0;
    pos                = '0;
    mode_next          = mode;
    count_next         = count;
    retired_count_next = retired_count;
    cycle_sum_next     = cycle_sum;
    proceed_next       = 1'b0;
    hit_next           = 1'b0;
    case (op)
      OP_CHECK_PC: begin
        if (!debug_enable) begin
          proceed_next = 1'b1;
        end else if (mode == MODE_PAUSED) begin
          proceed_next = 1'b0;
        end else if (mode == MODE_STEPPING) begin
          proceed_next = 1'b1;
        end else if (status.found_en) begin
          mode_next    = MODE_PAUSED;
          proceed_next = 1'b0;
        end else begin
          proceed_next = 1'b1;
        end
      end
      OP_RETIRE: begin
        retired_count_next = retired_count + 64'd1;
        cycle_sum_next     = cycle_sum + 64'(cycles_taken);
        if (debug_enable && mode == MODE_STEPPING) begin
          mode_next = MODE_PAUSED;
        end
      end
      OP_ADD: begin
        if (status.found_any) begin
          ctrl.reenable = start;
        end else if (not_full) begin
          ctrl.append = start;
          count_next  = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (32'(bp_index) < 32'(count)) begin
          ctrl.remove = start;
          pos         = CW'(bp_index);
          count_next  = count - CW'(1);
        end
      end
      OP_TOGGLE: begin
        if (status.found_any) begin
          ctrl.remove = start;
          pos         = found_idx;
          count_next  = count - CW'(1);
        end else if (not_full) begin
          ctrl.append = start;
          count_next  = count + CW'(1);
        end
      end
      OP_QUERY: begin
        hit_next = status.found_en;
      end
      OP_SET_MODE: begin
        if (new_mode <= MODE_STEPPING) begin
          mode_next = mode_t'(new_mode);
        end
      end
      OP_CLEAR_COUNTERS: begin
        retired_count_next = '0;
        cycle_sum_next     = '0;
        mode_next          = debug_enable ? MODE_PAUSED : MODE_RUNNING;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debug_enable  <= 1'b0;
      mode          <= MODE_RUNNING;
      count         <= '0;
      retired_count <= '0;
      cycle_sum     <= '0;
      done          <= 1'b0;
    end else begin
      if (cfg_we) begin
        debug_enable <= cfg_wdata;
      end
      done <= start;
      if (start) begin
        mode          <= mode_next;
        count         <= count_next;
        retired_count <= retired_count_next;
        cycle_sum     <= cycle_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      proceed <= proceed_next;
      hit     <= hit_next;
    end
  end

  assign run_mode     = mode;
  assign bp_count     = count;
  assign instr_total  = retired_count;
  assign cycles_total = cycle_sum;

  `BMU_ASSERT(a_count_bound, 32'(bp_count) <= 32'(MAX_BREAKPOINTS))
  `BMU_ASSERT_NEXT(a_beat_done, start && !busy, done)
  `BMU_ASSERT_NEXT(a_no_spurious_done, !start, !done)
  `BMU_ASSERT_NEXT(a_count_held, !start, $stable(bp_count))

endmodule

@@ bench/breakpoint_match_unit_test.sv @@
// Self-checking testbench for the breakpoint match unit: directed table, then random commands.
`timescale 1ns / 1ps

module breakpoint_match_unit_test;
  import bpm_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int POOL_SIZE = 24;
  localparam int PHASES = 6;
  localparam int PHASE_BEATS = 100;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [3:0]  idx;
    logic [11:0] cyc;
    logic [1:0]  nm;
  } cmd_t;

  typedef struct packed {
    logic        proceed;
    logic        hit;
    logic [1:0]  mode;
    logic [4:0]  count;
    logic [63:0] instr;
    logic [63:0] cycles;
  } rsp_t;

  typedef struct packed {
    logic dbg;
    logic fixed;
    cmd_t cmd;
    rsp_t rsp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [31:0] address = '0;
  logic [3:0]  bp_index = '0;
  logic [11:0] cycles_taken = '0;
  logic [1:0]  new_mode = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        done;
  logic        proceed;
  logic        hit;
  logic [1:0]  run_mode;
  logic [4:0]  bp_count;
  logic [63:0] instr_total;
  logic [63:0] cycles_total;

  // mirror of the block state
  logic [31:0] tbl_addr [NUM_SLOTS];
  logic        tbl_en [NUM_SLOTS];
  int          tbl_used;
  mode_t       cur_mode;
  logic [63:0] retired;
  logic [63:0] cyc_sum;
  logic        dbg_en;

  rsp_t        pending_rsp [$];
  rsp_t        exp_rsp;
  rsp_t        got_rsp;
  cmd_t        seen_cmd;
  logic        drv_fixed = 1'b0;
  rsp_t        drv_rsp = '0;
  int          fails = 0;
  int          tick_count = 0;
  logic [31:0] addr_pool [POOL_SIZE];
  dir_row_t    dir_tab [$];

  breakpoint_match_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .address      (address),
    .bp_index     (bp_index),
    .cycles_taken (cycles_taken),
    .new_mode     (new_mode),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .proceed      (proceed),
    .hit          (hit),
    .run_mode     (run_mode),
    .bp_count     (bp_count),
    .instr_total  (instr_total),
    .cycles_total (cycles_total)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    tick_count++;
    if (tick_count > CYCLE_LIMIT) begin
      $display("** breakpoint_match_unit: FAILED **");
      $finish;
    end
  end

  function automatic int bp_find(logic [31:0] a, logic need_en);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_addr[i] == a && (!need_en || tbl_en[i])) return i;
    end
    return -1;
  endfunction

  function automatic void bp_drop(int slot);
    if (slot >= tbl_used) return;
    for (int i = slot; i + 1 < tbl_used; i++) begin
      tbl_addr[i] = tbl_addr[i + 1];
      tbl_en[i] = tbl_en[i + 1];
    end
    tbl_used--;
  endfunction

  function automatic void bp_insert(logic [31:0] a);
    int f;
    f = bp_find(a, 1'b0);
    if (f >= 0) begin
      tbl_en[f] = 1'b1;
    end else if (tbl_used < NUM_SLOTS) begin
      tbl_addr[tbl_used] = a;
      tbl_en[tbl_used] = 1'b1;
      tbl_used++;
    end
  endfunction

  function automatic rsp_t bp_predict(cmd_t c);
    rsp_t r;
    logic [31:0] aligned;
    int f;
    r = '0;
    aligned = c.addr & ADDR_ALIGN_MASK;
    case (c.op)
      OP_CHECK_PC: begin
        if (!dbg_en || cur_mode == MODE_STEPPING) begin
          r.proceed = 1'b1;
        end else if (cur_mode == MODE_RUNNING) begin
          if (bp_find(c.addr, 1'b1) >= 0) cur_mode = MODE_PAUSED;
          else r.proceed = 1'b1;
        end
      end
      OP_RETIRE: begin
        retired = retired + 64'd1;
        cyc_sum = cyc_sum + {52'd0, c.cyc};
        if (dbg_en && cur_mode == MODE_STEPPING) cur_mode = MODE_PAUSED;
      end
      OP_ADD: bp_insert(aligned);
      OP_REMOVE: bp_drop(int'(c.idx));
      OP_TOGGLE: begin
        f = bp_find(aligned, 1'b0);
        if (f >= 0) bp_drop(f);
        else bp_insert(aligned);
      end
      OP_QUERY: r.hit = (bp_find(aligned, 1'b1) >= 0);
      OP_SET_MODE: begin
        if (c.nm <= MODE_STEPPING) cur_mode = mode_t'(c.nm);
      end
      default: begin
        retired = '0;
        cyc_sum = '0;
        cur_mode = dbg_en ? MODE_PAUSED : MODE_RUNNING;
      end
    endcase
    r.mode = cur_mode;
    r.count = tbl_used[4:0];
    r.instr = retired;
    r.cycles = cyc_sum;
    return r;
  endfunction

  // result check and prediction at each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) tbl_en[i] = 1'b0;
      tbl_used = 0;
      cur_mode = MODE_RUNNING;
      retired = '0;
      cyc_sum = '0;
      dbg_en = 1'b0;
    end else begin
      if (done) begin
        if (pending_rsp.size() == 0) begin
          $error("result beat with nothing pending");
          fails++;
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (proceed !== exp_rsp.proceed) begin
            $error("proceed: expected %0d, actual %0d", exp_rsp.proceed, proceed);
            fails++;
          end
          if (hit !== exp_rsp.hit) begin
            $error("hit: expected %0d, actual %0d", exp_rsp.hit, hit);
            fails++;
          end
          if (run_mode !== exp_rsp.mode) begin
            $error("run_mode: expected %0d, actual %0d", exp_rsp.mode, run_mode);
            fails++;
          end
          if (bp_count !== exp_rsp.count) begin
            $error("bp_count: expected %0d, actual %0d", exp_rsp.count, bp_count);
            fails++;
          end
          if (instr_total !== exp_rsp.instr) begin
            $error("instr_total: expected %0d, actual %0d", exp_rsp.instr, instr_total);
            fails++;
          end
          if (cycles_total !== exp_rsp.cycles) begin
            $error("cycles_total: expected %0d, actual %0d", exp_rsp.cycles, cycles_total);
            fails++;
          end
        end
      end
      if (cfg_we) dbg_en = cfg_wdata;
      if (start && !busy) begin
        seen_cmd.op = op_t'(opcode);
        seen_cmd.addr = address;
        seen_cmd.idx = bp_index;
        seen_cmd.cyc = cycles_taken;
        seen_cmd.nm = new_mode;
        got_rsp = bp_predict(seen_cmd);
        pending_rsp.push_back(drv_fixed ? drv_rsp : got_rsp);
      end
    end
  end

  task automatic send_beat(cmd_t c, int gap, logic fixed, rsp_t r);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    opcode <= c.op;
    address <= c.addr;
    bp_index <= c.idx;
    cycles_taken <= c.cyc;
    new_mode <= c.nm;
    drv_fixed <= fixed;
    drv_rsp <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_debug_enable(logic v);
    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic dir_row_t drow(logic dbg, op_t op, logic [31:0] a, logic [3:0] i,
                                    logic [11:0] c, logic [1:0] m);
    dir_row_t d;
    d = '0;
    d.dbg = dbg;
    d.cmd.op = op;
    d.cmd.addr = a;
    d.cmd.idx = i;
    d.cmd.cyc = c;
    d.cmd.nm = m;
    return d;
  endfunction

  function automatic dir_row_t trow(logic dbg, op_t op, logic [31:0] a, logic [11:0] c,
                                    logic p, logic h, mode_t md, logic [4:0] n,
                                    logic [63:0] it, logic [63:0] ct);
    dir_row_t d;
    d = drow(dbg, op, a, 4'd0, c, 2'd0);
    d.fixed = 1'b1;
    d.rsp.proceed = p;
    d.rsp.hit = h;
    d.rsp.mode = md;
    d.rsp.count = n;
    d.rsp.instr = it;
    d.rsp.cycles = ct;
    return d;
  endfunction

  function automatic op_t pick_op(logic fill);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fill && r < 45) return OP_ADD;
    r = $urandom_range(0, 99);
    if (r < 28) return OP_CHECK_PC;
    if (r < 46) return OP_RETIRE;
    if (r < 60) return OP_ADD;
    if (r < 68) return OP_REMOVE;
    if (r < 76) return OP_TOGGLE;
    if (r < 86) return OP_QUERY;
    if (r < 96) return OP_SET_MODE;
    return OP_CLEAR_COUNTERS;
  endfunction

  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    if ($urandom_range(0, 4) == 0) return $urandom;
    a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 3) == 0) a[0] = ~a[0];
    return a;
  endfunction

  function automatic int pick_gap(logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    cmd_t     c;
    dir_row_t d;
    logic     cur_dbg;
    logic     phase_dbg [PHASES];

    phase_dbg = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    // after reset, extremes, then the pause and step rules
    dir_tab.push_back(trow(0, OP_QUERY, 32'h0, 12'd0, 0, 0, MODE_RUNNING, 0, 0, 0));
    dir_tab.push_back(trow(0, OP_RETIRE, 32'h0, 12'd4095, 0, 0, MODE_RUNNING, 0, 1, 4095));
    dir_tab.push_back(trow(0, OP_RETIRE, 32'h0, 12'd0, 0, 0, MODE_RUNNING, 0, 2, 4095));
    dir_tab.push_back(trow(0, OP_ADD, 32'hFFFF_FFFF, 12'd0, 0, 0, MODE_RUNNING, 1, 2, 4095));
    dir_tab.push_back(trow(0, OP_QUERY, 32'hFFFF_FFFF, 12'd0, 0, 1, MODE_RUNNING, 1, 2, 4095));
    dir_tab.push_back(trow(0, OP_CHECK_PC, 32'hFFFF_FFFE, 12'd0, 1, 0, MODE_RUNNING, 1, 2,
                           4095));
    dir_tab.push_back(drow(0, OP_ADD, 32'h0000_0000, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(0, OP_ADD, 32'h0000_1235, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(0, OP_ADD, 32'h0000_1234, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(0, OP_SET_MODE, 32'h0, 4'd0, 12'd0, 2'd3));
    dir_tab.push_back(trow(0, OP_CLEAR_COUNTERS, 32'h0, 12'd0, 0, 0, MODE_RUNNING, 3, 0, 0));
    dir_tab.push_back(drow(1, OP_CHECK_PC, 32'h0000_1235, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(trow(1, OP_CHECK_PC, 32'h0000_1234, 12'd0, 0, 0, MODE_PAUSED, 3, 0, 0));
    dir_tab.push_back(drow(1, OP_CHECK_PC, 32'h0000_0000, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(1, OP_SET_MODE, 32'h0, 4'd0, 12'd0, 2'd2));
    dir_tab.push_back(drow(1, OP_CHECK_PC, 32'h0000_1234, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(1, OP_RETIRE, 32'h0, 4'd0, 12'd1, 2'd0));
    dir_tab.push_back(drow(1, OP_REMOVE, 32'h0, 4'd15, 12'd0, 2'd0));
    dir_tab.push_back(drow(1, OP_REMOVE, 32'h0, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(1, OP_TOGGLE, 32'h0000_1235, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(1, OP_TOGGLE, 32'h00AB_CDEF, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(1, OP_SET_MODE, 32'h0, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(drow(1, OP_CHECK_PC, 32'h00AB_CDEE, 4'd0, 12'd0, 2'd0));
    dir_tab.push_back(trow(1, OP_CLEAR_COUNTERS, 32'h0, 12'd0, 0, 0, MODE_PAUSED, 2, 0, 0));
    dir_tab.push_back(drow(1, OP_QUERY, 32'h0000_0001, 4'd0, 12'd0, 2'd0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_dbg = 1'b1;
    foreach (dir_tab[i]) begin
      d = dir_tab[i];
      if (d.dbg !== cur_dbg) begin
        write_debug_enable(d.dbg);
        cur_dbg = d.dbg;
      end
      send_beat(d.cmd, 0, d.fixed, d.rsp);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_debug_enable(phase_dbg[p]);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        c.op = pick_op(p == 3);
        c.addr = pick_addr();
        c.idx = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 15)) :
                                               4'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
          0: c.cyc = 12'd0;
          1: c.cyc = 12'd4095;
          default: c.cyc = 12'($urandom_range(0, 4095));
        endcase
        c.nm = 2'($urandom_range(0, 3));
        send_beat(c, pick_gap(p == 2), 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) $display("** breakpoint_match_unit: PASSED **");
    else $display("** breakpoint_match_unit: FAILED **");
    $finish;
  end

endmodule
